@@ rtl/core/lpse_pkg.sv @@
`default_nettype none

package lpse_pkg;

    localparam int unsigned ColorW   = 8;
    localparam int unsigned EncW     = 3 * ColorW;
    localparam int unsigned PixEncW  = 3 * EncW;
    localparam int unsigned SlotW    = 4;

    // register indexes of the configuration port
    localparam logic [1:0] CfgRainbow = 2'd0;
    localparam logic [1:0] CfgStart   = 2'd1;
    localparam logic [1:0] CfgStep    = 2'd2;

    localparam logic [7:0] StepReset  = 8'd10;

    // byte slots of one pixel: preamble, nine data bytes, trailer
    localparam logic [SlotW-1:0] SlotPre     = 4'd0;
    localparam logic [SlotW-1:0] SlotData0   = 4'd1;
    localparam logic [SlotW-1:0] SlotDataEnd = 4'd9;
    localparam logic [SlotW-1:0] SlotTrail   = 4'd10;

    localparam logic [7:0] WheelThird    = 8'd85;
    localparam logic [7:0] WheelTwoThird = 8'd170;
    localparam logic [7:0] ColorMax      = 8'd255;

    typedef struct packed {
        logic [PixEncW-1:0] bits;   // green, red, blue from the top down
        logic               first;
        logic               last;
    } t_enc_pix;

    // each data bit becomes 1b0, msb first
    function automatic logic [EncW-1:0] encode_byte(input logic [ColorW-1:0] v);
        logic [EncW-1:0] w;
        w = '0;
        for (int i = 0; i < ColorW; i++) begin
            w[3*i +: 3] = {1'b1, v[i], 1'b0};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lpse_encode.sv @@
`default_nettype none

module lpse_encode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_rainbow,
    input  wire logic [7:0]  i_start,
    input  wire logic [7:0]  i_step,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic        i_first,
    input  wire logic        i_last,
    output lpse_pkg::t_enc_pix o_enc
);

    logic [7:0] r_wheel;
    logic [7:0] n_wheel;
    logic [7:0] pos;
    logic [7:0] q;
    logic [8:0] q3_full;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] wr;
    logic [7:0] wg;
    logic [7:0] wb;
    logic [7:0] cr;
    logic [7:0] cg;
    logic [7:0] cb;
    logic [8:0] sum;

    assign pos = i_first ? i_start : r_wheel;

    always_comb begin
        if (pos < lpse_pkg::WheelThird) begin
            q = pos;
        end else if (pos < lpse_pkg::WheelTwoThird) begin
            q = pos - lpse_pkg::WheelThird;
        end else begin
            q = pos - lpse_pkg::WheelTwoThird;
        end
        q3_full = {q, 1'b0} + {1'b0, q};
        up      = q3_full[7:0];
        down    = lpse_pkg::ColorMax - up;
        if (pos < lpse_pkg::WheelThird) begin
            wr = up;
            wg = down;
            wb = '0;
        end else if (pos < lpse_pkg::WheelTwoThird) begin
            wr = down;
            wg = '0;
            wb = up;
        end else begin
            wr = '0;
            wg = up;
            wb = down;
        end
    end

    assign cr = i_rainbow ? wr : i_red;
    assign cg = i_rainbow ? wg : i_green;
    assign cb = i_rainbow ? wb : i_blue;

    assign o_enc = '{bits:  {lpse_pkg::encode_byte(cg), lpse_pkg::encode_byte(cr),
                             lpse_pkg::encode_byte(cb)},
                     first: i_first,
                     last:  i_last};

    // wheel wraps past 255 by taking 255 off
    assign sum = {1'b0, pos} + {1'b0, i_step};

    always_comb begin
        if (i_rainbow) begin
            n_wheel = sum[8] ? 8'(sum - {1'b0, lpse_pkg::ColorMax}) : sum[7:0];
        end else begin
            n_wheel = pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel <= '0;
        end else if (i_accept) begin
            r_wheel <= n_wheel;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lpse_serial.sv @@
`default_nettype none

module lpse_serial (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire lpse_pkg::t_enc_pix i_enc,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last
);

    logic                              r_busy;
    logic [lpse_pkg::PixEncW-1:0]      r_bits;
    logic                              r_last;
    logic [lpse_pkg::SlotW-1:0]        r_slot;
    logic                              r_out_valid;
    logic [7:0]                        r_out_byte;
    logic                              r_out_last;
    logic                              out_free;
    logic                              emit;
    logic [lpse_pkg::SlotW-1:0]        end_slot;
    logic                              at_end;
    logic                              in_data;
    logic [7:0]                        cur_byte;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = r_busy && out_free;
    assign end_slot = r_last ? lpse_pkg::SlotTrail : lpse_pkg::SlotDataEnd;
    assign at_end   = (r_slot == end_slot);
    assign in_data  = (r_slot >= lpse_pkg::SlotData0) && (r_slot <= lpse_pkg::SlotDataEnd);
    assign cur_byte = in_data ? r_bits[lpse_pkg::PixEncW-1 -: 8] : 8'd0;

    // next pixel may come in while its predecessor hands over its final word
    assign o_ready = !r_busy || (out_free && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (emit && at_end) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bits <= i_enc.bits;
            r_last <= i_enc.last;
            r_slot <= i_enc.first ? lpse_pkg::SlotPre : lpse_pkg::SlotData0;
        end else if (emit) begin
            r_slot <= r_slot + lpse_pkg::SlotW'(1);
            if (in_data) begin
                r_bits <= {r_bits[lpse_pkg::PixEncW-9:0], 8'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= at_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/led_pixel_spi_bit_encoder_top.sv @@
`default_nettype none

// Serial RGB LED strip encoder: one pixel word in, SPI bytes out.
// Slave channel: one pixel per word, red/green/blue in tdata, tuser marks the
// first pixel of a frame (zero preamble byte, color wheel restarts at the start
// value), tlast marks the last pixel (zero trailing byte follows).
// Master channel: one SPI byte per word, green then red then blue, every data bit
// sent as three line bits msb first; tlast is set on the final byte of a pixel.
// Configuration: write enable, register index and data; index 0 rainbow mode,
// 1 wheel start value, 2 wheel step. The user must write them only while the
// block is idle; the block does not enforce this. A pixel's first byte passes the
// pixel register, then the output register. Throughput: one output byte per
// cycle while master tready is high, 9 to 11 bytes per pixel; the serializer is
// the limit. A new pixel is taken in the cycle the previous one hands over its
// final byte, so the byte stream has no gaps. Stall: while tready on the master
// side is low the output byte holds and the serializer stops; while a pixel is
// pending the slave side is ready only in the cycle its final byte moves on.
// Reset: synchronous, active low; clears the wheel position, both channels and
// the configuration (rainbow off, start 0, step 10).
module led_pixel_spi_bit_encoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  wire logic        s_axis_tuser,   // first_pixel
    input  wire logic        s_axis_tlast,   // last_pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // spi_byte [7:0]
    output logic             m_axis_tlast,   // last_byte
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);

    logic               r_rainbow;
    logic [7:0]         r_start;
    logic [7:0]         r_step;
    logic               load;
    lpse_pkg::t_enc_pix enc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rainbow <= 1'b0;
            r_start   <= '0;
            r_step    <= lpse_pkg::StepReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpse_pkg::CfgRainbow: r_rainbow <= i_cfg_data[0];
                lpse_pkg::CfgStart:   r_start   <= i_cfg_data;
                lpse_pkg::CfgStep:    r_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign load = s_axis_tvalid && s_axis_tready;

    lpse_encode u_encode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (load),
        .i_rainbow (r_rainbow),
        .i_start   (r_start),
        .i_step    (r_step),
        .i_red     (s_axis_tdata[7:0]),
        .i_green   (s_axis_tdata[15:8]),
        .i_blue    (s_axis_tdata[23:16]),
        .i_first   (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .o_enc     (enc)
    );

    lpse_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_enc       (enc),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire
